>>> hw/rtl/zfbs_pkg.sv
`timescale 1ns / 1ps

package zfbs_pkg;

    // Frame magic numbers
    localparam logic [31:0] MAGIC_REGULAR   = 32'hFD2FB528;
    localparam logic [31:0] MAGIC_SKIP_BASE = 32'h184D2A50;
    localparam logic [31:0] MAGIC_SKIP_MASK = 32'hFFFFFFF0;

    // Result status codes
    localparam logic [1:0] ST_MORE  = 2'd0;
    localparam logic [1:0] ST_END   = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Section codes reported with each byte
    localparam logic [2:0] SEC_MAGIC     = 3'd0;
    localparam logic [2:0] SEC_SKIP_SIZE = 3'd1;
    localparam logic [2:0] SEC_SKIP_DATA = 3'd2;
    localparam logic [2:0] SEC_FRAME_HDR = 3'd3;
    localparam logic [2:0] SEC_BLOCK_HDR = 3'd4;
    localparam logic [2:0] SEC_BLOCK_DAT = 3'd5;
    localparam logic [2:0] SEC_CHECKSUM  = 3'd6;

    // Block types
    localparam logic [1:0] BT_RLE      = 2'd1;
    localparam logic [1:0] BT_RESERVED = 2'd3;

    // Parser phase, one-hot
    typedef enum logic [6:0] {
        PH_MAGIC     = 7'b0000001,
        PH_SKIP_SIZE = 7'b0000010,
        PH_SKIP_DATA = 7'b0000100,
        PH_FRAME_HDR = 7'b0001000,
        PH_BLOCK_HDR = 7'b0010000,
        PH_BLOCK_DAT = 7'b0100000,
        PH_CHECKSUM  = 7'b1000000
    } phase_t;

    // Complete parser state carried between bytes
    typedef struct packed {
        phase_t      phase;
        logic [4:0]  cnt;        // bytes of current field
        logic [31:0] value;      // little-endian field being gathered
        logic [7:0]  desc;       // frame header descriptor
        logic [4:0]  hdr_len;    // full frame header length incl. magic
        logic [31:0] remaining;  // body bytes still to skip
        logic        csum;       // checksum follows last block
        logic        final_blk;  // current block is the last one
        logic        err;        // sticky error
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:     PH_MAGIC,
        cnt:       5'd0,
        value:     32'd0,
        desc:      8'd0,
        hdr_len:   5'd0,
        remaining: 32'd0,
        csum:      1'b0,
        final_blk: 1'b0,
        err:       1'b0
    };

    // Section code of a phase; anything unknown reads as magic
    function automatic logic [2:0] phase_section(input phase_t ph);
        logic [2:0] sec;
        case (ph)
            PH_MAGIC:     sec = SEC_MAGIC;
            PH_SKIP_SIZE: sec = SEC_SKIP_SIZE;
            PH_SKIP_DATA: sec = SEC_SKIP_DATA;
            PH_FRAME_HDR: sec = SEC_FRAME_HDR;
            PH_BLOCK_HDR: sec = SEC_BLOCK_HDR;
            PH_BLOCK_DAT: sec = SEC_BLOCK_DAT;
            PH_CHECKSUM:  sec = SEC_CHECKSUM;
            default:      sec = SEC_MAGIC;
        endcase
        return sec;
    endfunction

    // Frame header length (with magic) from the descriptor byte
    function automatic logic [4:0] header_len_of(input logic [7:0] fhd);
        logic [4:0] dict_len;
        logic [4:0] fcs_len;
        logic       single;
        single = fhd[5];
        case (fhd[1:0])
            2'd0:    dict_len = 5'd0;
            2'd1:    dict_len = 5'd1;
            2'd2:    dict_len = 5'd2;
            default: dict_len = 5'd4;
        endcase
        case (fhd[7:6])
            2'd0:    fcs_len = 5'd0;
            2'd1:    fcs_len = 5'd2;
            2'd2:    fcs_len = 5'd4;
            default: fcs_len = 5'd8;
        endcase
        return 5'd5 + {4'd0, ~single} + dict_len + fcs_len
             + {4'd0, single && (fhd[7:6] == 2'd0)};
    endfunction

endpackage

>>> hw/rtl/zstd_frame_boundary_skipper.sv
`timescale 1ns / 1ps

// Zstandard frame boundary scanner.
// Input stream (s_axis_*): one byte of the compressed stream per request.
// Output stream (m_axis_*): one result per input byte, in order, giving the
// section the byte belongs to and whether it continues a frame, ends one,
// or is in error (bad magic or reserved block type).
// Latency: the result for a byte is valid the cycle after the byte is taken.
// Throughput: one byte per cycle while results are taken; the parser state and the result register
// both update in the cycle a byte is accepted.
// Stall: s_axis_tready is high while the result register is empty or being
// taken, so a stalled receiver holds one result and then stops the input.
// Reset: the parser returns to expecting a frame magic number and any latched
// error is cleared. An error stays latched until reset; every later byte
// answers error with the section where it occurred.
module zstd_frame_boundary_skipper
    import zfbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [1:0] status, [4:2] section, [7:5] zero
);

    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    logic [1:0]   out_status_reg;
    logic [2:0]   out_section_reg;
    logic [1:0]   status_next;
    logic [2:0]   section_next;
    logic         in_accept;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Per-byte parser step
    zfbs_parse u_parse (
        .cur        (state_reg),
        .byte_value (s_axis_tdata),
        .nxt        (state_next),
        .status     (status_next),
        .section    (section_next)
    );

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_status_reg  <= status_next;
            out_section_reg <= section_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_section_reg, out_status_reg};

endmodule

>>> hw/rtl/zfbs_parse.sv
`timescale 1ns / 1ps

module zfbs_parse
    import zfbs_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   byte_value,
    output parse_state_t nxt,
    output logic [1:0]   status,
    output logic [2:0]   section
);

    logic [31:0] gval;
    logic [4:0]  cnt_inc;
    logic [31:0] rem_dec;
    logic [7:0]  desc_n;
    logic [4:0]  hl_n;
    logic [1:0]  blk_type;
    logic [20:0] blk_size;

    // Little-endian gather of the first four bytes of a field
    always_comb
    begin
        gval = cur.value;
        if (cur.cnt < 5'd4)
        begin
            gval = cur.value | ({24'd0, byte_value} << {cur.cnt[1:0], 3'b000});
        end
    end

    assign cnt_inc  = cur.cnt + 5'd1;
    assign rem_dec  = cur.remaining - 32'd1;
    assign desc_n   = (cur.cnt == 5'd4) ? byte_value : cur.desc;
    assign hl_n     = (cur.cnt == 5'd4) ? header_len_of(byte_value) : cur.hdr_len;
    assign blk_type = gval[2:1];
    assign blk_size = (blk_type == BT_RLE) ? 21'd1 : gval[23:3];

    // Next state and result for one byte
    always_comb
    begin
        nxt     = cur;
        status  = ST_MORE;
        section = phase_section(cur.phase);
        if (cur.err)
        begin
            status = ST_ERROR;
        end
        else
        begin
            case (cur.phase)
                PH_MAGIC:
                begin
                    nxt.value = gval;
                    nxt.cnt   = cnt_inc;
                    if (cnt_inc >= 5'd4)
                    begin
                        if ((gval & MAGIC_SKIP_MASK) == MAGIC_SKIP_BASE)
                        begin
                            nxt.phase = PH_SKIP_SIZE;
                            nxt.cnt   = 5'd0;
                            nxt.value = 32'd0;
                        end
                        else if (gval == MAGIC_REGULAR)
                        begin
                            nxt.phase = PH_FRAME_HDR;
                        end
                        else
                        begin
                            nxt.err = 1'b1;
                            status  = ST_ERROR;
                        end
                    end
                end
                PH_SKIP_SIZE:
                begin
                    nxt.value = gval;
                    nxt.cnt   = cnt_inc;
                    if (cnt_inc >= 5'd4)
                    begin
                        nxt.remaining = gval;
                        nxt.cnt       = 5'd0;
                        nxt.value     = 32'd0;
                        if (gval == 32'd0)
                        begin
                            nxt.phase = PH_MAGIC;
                            status    = ST_END;
                        end
                        else
                        begin
                            nxt.phase = PH_SKIP_DATA;
                        end
                    end
                end
                PH_SKIP_DATA, PH_CHECKSUM:
                begin
                    nxt.remaining = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        nxt.phase = PH_MAGIC;
                        nxt.cnt   = 5'd0;
                        nxt.value = 32'd0;
                        status    = ST_END;
                    end
                end
                PH_FRAME_HDR:
                begin
                    // header bytes are counted; the descriptor byte also sets the header length
                    nxt.desc    = desc_n;
                    nxt.hdr_len = hl_n;
                    nxt.cnt     = cnt_inc;
                    if (cnt_inc >= 5'd5 && cnt_inc >= hl_n)
                    begin
                        nxt.csum  = desc_n[2];
                        nxt.cnt   = 5'd0;
                        nxt.value = 32'd0;
                        nxt.phase = PH_BLOCK_HDR;
                    end
                end
                PH_BLOCK_HDR:
                begin
                    nxt.value = gval;
                    nxt.cnt   = cnt_inc;
                    if (cnt_inc >= 5'd3)
                    begin
                        if (blk_type == BT_RESERVED)
                        begin
                            nxt.err = 1'b1;
                            status  = ST_ERROR;
                        end
                        else
                        begin
                            nxt.remaining = {11'd0, blk_size};
                            nxt.final_blk = gval[0];
                            nxt.cnt       = 5'd0;
                            nxt.value     = 32'd0;
                            if (blk_size != 21'd0)
                            begin
                                nxt.phase = PH_BLOCK_DAT;
                            end
                            else if (gval[0])
                            begin
                                // empty last block
                                if (cur.csum)
                                begin
                                    nxt.remaining = 32'd4;
                                    nxt.phase     = PH_CHECKSUM;
                                end
                                else
                                begin
                                    nxt.phase = PH_MAGIC;
                                    status    = ST_END;
                                end
                            end
                        end
                    end
                end
                PH_BLOCK_DAT:
                begin
                    nxt.remaining = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        if (cur.final_blk)
                        begin
                            if (cur.csum)
                            begin
                                nxt.remaining = 32'd4;
                                nxt.phase     = PH_CHECKSUM;
                            end
                            else
                            begin
                                nxt.phase = PH_MAGIC;
                                nxt.cnt   = 5'd0;
                                nxt.value = 32'd0;
                                status    = ST_END;
                            end
                        end
                        else
                        begin
                            nxt.cnt   = 5'd0;
                            nxt.value = 32'd0;
                            nxt.phase = PH_BLOCK_HDR;
                        end
                    end
                end
                default:
                begin
                    nxt.err = 1'b1;
                    status  = ST_ERROR;
                    section = SEC_MAGIC;
                end
            endcase
        end
    end

endmodule
